>>> src/hashed_polar_point_scatter_macros.svh
// ----------------------------------------------------------------------------
// hashed_polar_point_scatter_macros.svh
// Assertion macros shared by the scatter checker.
// ----------------------------------------------------------------------------
`ifndef HASHED_POLAR_POINT_SCATTER_MACROS_SVH
`define HASHED_POLAR_POINT_SCATTER_MACROS_SVH

// clocked check, masked while reset is asserted
`define HPPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define HPPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hpps_pkg.sv
// ----------------------------------------------------------------------------
// hpps_pkg
// Request types and fixed constants of the hashed polar point scatter.
// ----------------------------------------------------------------------------
package hpps_pkg;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic        [31:0] dot_index;
        logic        [15:0] spread_radius;
    } point_t;

    typedef struct packed {
        logic signed [15:0] moved_x;
        logic signed [15:0] moved_y;
    } moved_t;

    // hash constants
    localparam logic [31:0] HASH_MUL  = 32'd2654435761;
    localparam logic [31:0] HASH_ADD  = 32'h9E3779B1;
    localparam logic [31:0] FMIX_MUL1 = 32'h85EBCA6B;
    localparam logic [31:0] FMIX_MUL2 = 32'hC2B2AE35;

    // CORDIC, Q2.30, angles in 2^-32 turn
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // final placement: offsets are Q.35
    localparam int FRAC_SHIFT  = 35;
    localparam int SUM_W       = 52;
    localparam int CLAMP_LIMIT = 32760;

    function automatic logic signed [31:0] atan_turn(input logic [3:0] step);
        logic signed [31:0] a;
        unique case (step)
            4'd0:  a = 32'sh20000000;
            4'd1:  a = 32'sh12E4051E;
            4'd2:  a = 32'sh09FB385B;
            4'd3:  a = 32'sh051111D4;
            4'd4:  a = 32'sh028B0D43;
            4'd5:  a = 32'sh0145D7E1;
            4'd6:  a = 32'sh00A2F61E;
            4'd7:  a = 32'sh00517C55;
            4'd8:  a = 32'sh0028BE53;
            4'd9:  a = 32'sh00145F2F;
            4'd10: a = 32'sh000A2F98;
            4'd11: a = 32'sh000517CC;
            4'd12: a = 32'sh00028BE6;
            4'd13: a = 32'sh000145F3;
            4'd14: a = 32'sh0000A2F9;
            4'd15: a = 32'sh0000517D;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

endpackage

>>> src/hashed_polar_point_scatter.sv
// ----------------------------------------------------------------------------
// hashed_polar_point_scatter
// Moves a point by a repeatable hashed polar offset (fmix32-style hash, CORDIC).
// ----------------------------------------------------------------------------
// Pipeline: 24 register stages. Throughput: one request per cycle while the
// output is not stalled; 4 hash/scale stages, 16 CORDIC stages, 4 rounding,
// multiply, add and clamp stages.
// Stalls collapse bubbles: a stage holds only when it and all later stages
// are full. Reset clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hashed_polar_point_scatter #(
    parameter int ANGLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_stall,
    input  hpps_pkg::point_t point_req,
    output logic            moved_valid,
    input  logic            moved_stall,
    output hpps_pkg::moved_t moved_req
);

    localparam int NSTG   = 4 + hpps_pkg::CORDIC_STEPS + 4;
    localparam int CS0    = 4;
    localparam int ST_ROT = CS0 + hpps_pkg::CORDIC_STEPS;
    localparam int ST_MUL = ST_ROT + 1;
    localparam int ST_SUM = ST_MUL + 1;
    localparam int ST_OUT = ST_SUM + 1;
    localparam logic [31:0] TURN_MASK = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
    localparam logic signed [hpps_pkg::SUM_W-1:0] SUM_LIM =
        hpps_pkg::SUM_W'(hpps_pkg::CLAMP_LIMIT) << hpps_pkg::FRAC_SHIFT;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               pass;
    } keep_t;

    typedef struct packed {
        logic [1:0]  quad;
        logic [31:0] span;
        keep_t       keep;
    } side_t;

    function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [17:0] r;
        logic signed [15:0] q;
        t = 33'(v) + 33'sd16384;
        r = 18'(t >>> 15);
        if (r > 18'sd32767)
            q = 16'sd32767;
        else if (r < -18'sd32767)
            q = -16'sd32767;
        else
            q = 16'(r);
        return q;
    endfunction

    function automatic logic signed [15:0] place(
        input logic signed [hpps_pkg::SUM_W-1:0] sum
    );
        logic signed [15:0] q;
        logic               up;
        // floor, then step toward zero for negative sums with a fraction
        q  = sum[hpps_pkg::FRAC_SHIFT+15:hpps_pkg::FRAC_SHIFT];
        up = sum[hpps_pkg::SUM_W-1] && (|sum[hpps_pkg::FRAC_SHIFT-1:0]);
        if (sum > SUM_LIM)
            q = 16'(hpps_pkg::CLAMP_LIMIT);
        else if (sum < -SUM_LIM)
            q = -16'(hpps_pkg::CLAMP_LIMIT);
        else
            q = q + 16'(up);
        return q;
    endfunction

    function automatic logic signed [hpps_pkg::SUM_W-1:0] base_ext(
        input logic signed [15:0] p
    );
        return {{(hpps_pkg::SUM_W - 16 - hpps_pkg::FRAC_SHIFT){p[15]}}, p,
                {hpps_pkg::FRAC_SHIFT{1'b0}}};
    endfunction

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] ready;

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_flow
            assign ready[g] = !(&v_reg[NSTG-1:g]) || !moved_stall;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (ready[g])
                begin
                    if (g == 0)
                        v_reg[g] <= point_valid;
                    else
                        v_reg[g] <= v_reg[(g == 0) ? 0 : g - 1];
                end
            end
        end
    endgenerate

    assign point_stall = !ready[0];
    assign moved_valid = v_reg[ST_OUT];

    // ------------------------------------------------------------------
    // hash stages
    // ------------------------------------------------------------------
    logic [31:0] s0_h1_reg, s0_h2_reg, s1_h1_reg, s1_h2_reg, s2_h1_reg, s2_h2_reg;
    logic [15:0] s0_rad_reg, s1_rad_reg, s2_rad_reg;
    keep_t       s0_keep_reg, s1_keep_reg, s2_keep_reg, s3_keep_reg;
    logic [31:0] s3_turn_reg, s3_dist_reg;

    logic [31:0] seed1, seed2;
    logic [31:0] m1_h1, m1_h2, m2_h1, m2_h2, f_h1, f_h2;
    logic [47:0] dist_prod;
    keep_t       keep_next;

    always_comb
    begin
        seed1 = {point_req.dot_index[30:0], 1'b0};
        seed2 = {point_req.dot_index[30:0], 1'b1};
        keep_next.px   = point_req.point_x;
        keep_next.py   = point_req.point_y;
        keep_next.pass = (point_req.spread_radius == 16'd0);
        m1_h1 = (s0_h1_reg ^ (s0_h1_reg >> 15)) * hpps_pkg::FMIX_MUL1;
        m1_h2 = (s0_h2_reg ^ (s0_h2_reg >> 15)) * hpps_pkg::FMIX_MUL1;
        m2_h1 = (s1_h1_reg ^ (s1_h1_reg >> 13)) * hpps_pkg::FMIX_MUL2;
        m2_h2 = (s1_h2_reg ^ (s1_h2_reg >> 13)) * hpps_pkg::FMIX_MUL2;
        f_h1  = s2_h1_reg ^ (s2_h1_reg >> 16);
        f_h2  = s2_h2_reg ^ (s2_h2_reg >> 16);
        dist_prod = 48'(f_h2) * 48'(s2_rad_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            s0_h1_reg   <= seed1 * hpps_pkg::HASH_MUL + hpps_pkg::HASH_ADD;
            s0_h2_reg   <= seed2 * hpps_pkg::HASH_MUL + hpps_pkg::HASH_ADD;
            s0_rad_reg  <= point_req.spread_radius;
            s0_keep_reg <= keep_next;
        end
        if (ready[1])
        begin
            s1_h1_reg   <= m1_h1;
            s1_h2_reg   <= m1_h2;
            s1_rad_reg  <= s0_rad_reg;
            s1_keep_reg <= s0_keep_reg;
        end
        if (ready[2])
        begin
            s2_h1_reg   <= m2_h1;
            s2_h2_reg   <= m2_h2;
            s2_rad_reg  <= s1_rad_reg;
            s2_keep_reg <= s1_keep_reg;
        end
        if (ready[3])
        begin
            s3_turn_reg <= f_h1 & TURN_MASK;
            s3_dist_reg <= dist_prod[47:16];
            s3_keep_reg <= s2_keep_reg;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one step per stage
    // ------------------------------------------------------------------
    logic signed [31:0] cx_reg [hpps_pkg::CORDIC_STEPS];
    logic signed [31:0] cy_reg [hpps_pkg::CORDIC_STEPS];
    logic signed [31:0] cz_reg [hpps_pkg::CORDIC_STEPS];
    side_t              cs_reg [hpps_pkg::CORDIC_STEPS];

    generate
        for (g = 0; g < hpps_pkg::CORDIC_STEPS; g++) begin : g_cordic
            logic signed [31:0] x_in, y_in, z_in;
            side_t              s_in;
            logic signed [31:0] x_next, y_next, z_next;

            if (g == 0) begin : g_first
                always_comb
                begin
                    x_in = hpps_pkg::CORDIC_GAIN;
                    y_in = 32'sd0;
                    z_in = {2'b00, s3_turn_reg[29:0]};
                    s_in.quad = s3_turn_reg[31:30];
                    s_in.span = s3_dist_reg;
                    s_in.keep = s3_keep_reg;
                end
            end
            else begin : g_rest
                always_comb
                begin
                    x_in = cx_reg[(g == 0) ? 0 : g - 1];
                    y_in = cy_reg[(g == 0) ? 0 : g - 1];
                    z_in = cz_reg[(g == 0) ? 0 : g - 1];
                    s_in = cs_reg[(g == 0) ? 0 : g - 1];
                end
            end

            always_comb
            begin
                if (!z_in[31])
                begin
                    x_next = x_in - (y_in >>> g);
                    y_next = y_in + (x_in >>> g);
                    z_next = z_in - hpps_pkg::atan_turn(4'(g));
                end
                else
                begin
                    x_next = x_in + (y_in >>> g);
                    y_next = y_in - (x_in >>> g);
                    z_next = z_in + hpps_pkg::atan_turn(4'(g));
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[CS0 + g])
                begin
                    cx_reg[g] <= x_next;
                    cy_reg[g] <= y_next;
                    cz_reg[g] <= z_next;
                    cs_reg[g] <= s_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // rounding, quadrant fold, offset multiply, add, clamp
    // ------------------------------------------------------------------
    localparam int LAST = hpps_pkg::CORDIC_STEPS - 1;

    logic signed [15:0] cq, sq, cos_next, sin_next;
    logic signed [15:0] r_cos_reg, r_sin_reg;
    logic [31:0]        r_dist_reg;
    keep_t              r_keep_reg, m_keep_reg, a_keep_reg;
    logic signed [48:0] m_offx_reg, m_offy_reg;
    logic signed [32:0] dist_s;
    logic signed [hpps_pkg::SUM_W-1:0] a_sumx_reg, a_sumy_reg;
    hpps_pkg::moved_t   out_reg, out_next;

    always_comb
    begin
        cq = to_q15(cx_reg[LAST]);
        sq = to_q15(cy_reg[LAST]);
        unique case (cs_reg[LAST].quad)
            2'd0:
            begin
                cos_next = cq;
                sin_next = sq;
            end
            2'd1:
            begin
                cos_next = -sq;
                sin_next = cq;
            end
            2'd2:
            begin
                cos_next = -cq;
                sin_next = -sq;
            end
            default:
            begin
                cos_next = sq;
                sin_next = -cq;
            end
        endcase
        dist_s = $signed({1'b0, r_dist_reg});
        if (a_keep_reg.pass)
        begin
            out_next.moved_x = a_keep_reg.px;
            out_next.moved_y = a_keep_reg.py;
        end
        else
        begin
            out_next.moved_x = place(a_sumx_reg);
            out_next.moved_y = place(a_sumy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_ROT])
        begin
            r_cos_reg  <= cos_next;
            r_sin_reg  <= sin_next;
            r_dist_reg <= cs_reg[LAST].span;
            r_keep_reg <= cs_reg[LAST].keep;
        end
        if (ready[ST_MUL])
        begin
            m_offx_reg <= dist_s * r_cos_reg;
            m_offy_reg <= dist_s * r_sin_reg;
            m_keep_reg <= r_keep_reg;
        end
        if (ready[ST_SUM])
        begin
            a_sumx_reg <= base_ext(m_keep_reg.px) + hpps_pkg::SUM_W'(m_offx_reg);
            a_sumy_reg <= base_ext(m_keep_reg.py) + hpps_pkg::SUM_W'(m_offy_reg);
            a_keep_reg <= m_keep_reg;
        end
        if (ready[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign moved_req = out_reg;

endmodule

>>> src/hpps_checker.sv
// ----------------------------------------------------------------------------
// hpps_checker
// Port-level checks of the scatter pipeline handshakes, bound to the top.
// ----------------------------------------------------------------------------
`include "hashed_polar_point_scatter_macros.svh"

module hpps_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             point_valid,
    input logic             point_stall,
    input logic             moved_valid,
    input logic             moved_stall,
    input hpps_pkg::moved_t moved_req
);

    // a held result keeps its value
    `HPPS_ASSERT(a_moved_hold, moved_valid && moved_stall |=> moved_valid && $stable(moved_req), "stalled result changed")

    // input backs up only when every stage is full and the output is held
    `HPPS_ASSERT(a_stall_full, point_stall |-> moved_valid && moved_stall, "input stalled with room in pipe")

    // a clock edge in reset empties the pipe and opens the input
    `HPPS_ASSERT_RST(a_rst_empty, !rst_n |=> !moved_valid && !point_stall, "pipe not empty in reset")

    // a full pipe that was not drained stays full at the output
    `HPPS_ASSERT(a_full_keeps, point_stall && !point_valid |=> moved_valid, "result lost under stall")

endmodule

bind hashed_polar_point_scatter hpps_checker u_hpps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .moved_valid (moved_valid),
    .moved_stall (moved_stall),
    .moved_req   (moved_req)
);

>>> tb/hashed_polar_point_scatter_tb.sv
// ----------------------------------------------------------------------------
// hashed_polar_point_scatter_tb
// Self-checking bench for the hashed polar point scatter. Requests are driven
// with random sender gaps and receiver stalls; a scoreboard predicts each
// moved point from its own hash, CORDIC and clamp arithmetic and checks the
// results in order.
// ----------------------------------------------------------------------------
module hashed_polar_point_scatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS    = 16;
    localparam int RANDOM_POINTS = 800;
    localparam int CALM_AFTER    = 680;
    localparam int DRAIN_CYCLES  = 40;

    localparam longint UNIT_Q35  = 64'sd1 <<< 35;
    localparam longint LIMIT_Q35 = 64'sd32760 <<< 35;
    localparam longint START_GAIN = 64'sd652032874;

    // atan(2^-i) in 2^-32 turn
    localparam longint ATAN_TURN [16] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2F9, 64'sh0000517D
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             point_valid = 1'b0;
    logic             point_stall;
    hpps_pkg::point_t point_req   = '0;
    logic             moved_valid;
    logic             moved_stall = 1'b0;
    hpps_pkg::moved_t moved_req;
    bit               calm        = 1'b0;

    class scatter_scoreboard;
        hpps_pkg::moved_t pending_moves[$];
        int     mismatches;
        int     points_noted;
        int     moves_checked;
        int     still_points;
        int     clamped_axes;

        function logic [31:0] fmix_hash(logic [31:0] seed);
            logic [31:0] h;
            h = seed * 32'd2654435761 + 32'h9E3779B1;
            h = h ^ (h >> 15);
            h = h * 32'h85EBCA6B;
            h = h ^ (h >> 13);
            h = h * 32'hC2B2AE35;
            h = h ^ (h >> 16);
            return h;
        endfunction

        function longint round_q15(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767)
                r = 32767;
            if (r < -32767)
                r = -32767;
            return r;
        endfunction

        function void unit_vector(logic [31:0] turn, output longint c, output longint s);
            longint vx, vy, z, dx, dy, cq, sq;
            vx = START_GAIN;
            vy = 0;
            z  = longint'({2'b00, turn[29:0]});
            for (int i = 0; i < 16; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (z >= 0)
                begin
                    vx = vx - dx;
                    vy = vy + dy;
                    z  = z - ATAN_TURN[i];
                end
                else
                begin
                    vx = vx + dx;
                    vy = vy - dy;
                    z  = z + ATAN_TURN[i];
                end
            end
            cq = round_q15(vx);
            sq = round_q15(vy);
            unique case (turn[31:30])
                2'd0:    begin c = cq;  s = sq;  end
                2'd1:    begin c = -sq; s = cq;  end
                2'd2:    begin c = -cq; s = -sq; end
                default: begin c = sq;  s = -cq; end
            endcase
        endfunction

        function logic [15:0] place_axis(longint base, longint offset);
            longint sum;
            sum = base * UNIT_Q35 + offset;
            if (sum > LIMIT_Q35)
            begin
                sum = LIMIT_Q35;
                clamped_axes++;
            end
            if (sum < -LIMIT_Q35)
            begin
                sum = -LIMIT_Q35;
                clamped_axes++;
            end
            return 16'(sum / UNIT_Q35);
        endfunction

        function hpps_pkg::moved_t predict_move(hpps_pkg::point_t p);
            hpps_pkg::moved_t m;
            logic [31:0]      h1, h2, turn;
            longint           reach, c, s;
            if (p.spread_radius == 16'd0)
            begin
                // pass through, no clamp
                still_points++;
                m.moved_x = p.point_x;
                m.moved_y = p.point_y;
                return m;
            end
            h1    = fmix_hash({p.dot_index[30:0], 1'b0});
            h2    = fmix_hash({p.dot_index[30:0], 1'b1});
            turn  = (h1 >> (32 - ANGLE_BITS)) << (32 - ANGLE_BITS);
            reach = longint'(({32'd0, h2} * {48'd0, p.spread_radius}) >> 16);
            unit_vector(turn, c, s);
            m.moved_x = place_axis(longint'($signed(p.point_x)), reach * c);
            m.moved_y = place_axis(longint'($signed(p.point_y)), reach * s);
            return m;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function void note_point(hpps_pkg::point_t p);
            points_noted++;
            pending_moves.push_back(predict_move(p));
        endfunction

        task check_moved(hpps_pkg::moved_t got);
            hpps_pkg::moved_t want;
            if (pending_moves.size() == 0)
            begin
                report_mismatch($sformatf("result x=%0d y=%0d with no request pending",
                                          $signed(got.moved_x), $signed(got.moved_y)));
                return;
            end
            want = pending_moves.pop_front();
            moves_checked++;
            if (got.moved_x !== want.moved_x)
                report_mismatch($sformatf("moved_x got %0d want %0d",
                                          $signed(got.moved_x), $signed(want.moved_x)));
            if (got.moved_y !== want.moved_y)
                report_mismatch($sformatf("moved_y got %0d want %0d",
                                          $signed(got.moved_y), $signed(want.moved_y)));
        endtask
    endclass

    scatter_scoreboard board;

    hashed_polar_point_scatter #(
        .ANGLE_BITS (ANGLE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_req   (point_req),
        .moved_valid (moved_valid),
        .moved_stall (moved_stall),
        .moved_req   (moved_req)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", board.pending_moves.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic hpps_pkg::point_t make_point(int x, int y, logic [31:0] idx,
                                                    int radius);
        hpps_pkg::point_t p;
        p.point_x       = 16'(x);
        p.point_y       = 16'(y);
        p.dot_index     = idx;
        p.spread_radius = 16'(radius);
        return p;
    endfunction

    function automatic logic [15:0] random_coord();
        if ($urandom_range(0, 4) != 0)
            return 16'($urandom());
        // near the rails, where clamping bites
        if ($urandom_range(0, 1) != 0)
            return 16'(32767 - $urandom_range(0, 16));
        return 16'(-32768 + $urandom_range(0, 16));
    endfunction

    function automatic hpps_pkg::point_t random_point();
        hpps_pkg::point_t p;
        int               pick;
        p.point_x   = random_coord();
        p.point_y   = random_coord();
        p.dot_index = $urandom();
        pick = $urandom_range(0, 9);
        unique case (pick)
            0:       p.spread_radius = 16'd0;
            1:       p.spread_radius = 16'hFFFF;
            2, 3, 4: p.spread_radius = 16'($urandom_range(1, 255));
            default: p.spread_radius = 16'($urandom());
        endcase
        return p;
    endfunction

    task idle_sender();
        int n;
        if (calm || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 15);
        point_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task send_point(hpps_pkg::point_t p);
        idle_sender();
        point_valid <= 1'b1;
        point_req   <= p;
        do
            @(posedge clk);
        while (point_stall !== 1'b0);
        board.note_point(p);
    endtask

    task run_directed();
        // zero radius passes the rails through unclamped
        send_point(make_point(-32768, 32767, 32'd0, 0));
        send_point(make_point(32767, -32768, 32'hFFFFFFFF, 0));
        send_point(make_point(0, 0, 32'h12345678, 0));
        // smallest and largest radius
        send_point(make_point(0, 0, 32'd0, 1));
        send_point(make_point(0, 0, 32'd1, 16));
        send_point(make_point(0, 0, 32'hFFFFFFFF, 65535));
        send_point(make_point(0, 0, 32'h80000000, 65535));
        send_point(make_point(0, 0, 32'h7FFFFFFF, 65535));
        // nonzero radius at the rails forces the clamp
        send_point(make_point(32767, 32767, 32'd2, 65535));
        send_point(make_point(-32768, -32768, 32'd3, 65535));
        send_point(make_point(32767, -32768, 32'd4, 1));
        send_point(make_point(-32768, 32767, 32'd5, 1));
        send_point(make_point(32760, -32760, 32'd6, 32768));
        // consecutive indices spread the phase over all quadrants
        for (int i = 0; i < 10; i++)
            send_point(make_point(100 * i - 500, 500 - 100 * i, 32'(i + 16), 65535));
    endtask

    initial
    begin : stimulus
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            if (n == CALM_AFTER)
                calm = 1'b1;
            send_point(random_point());
        end
        point_valid <= 1'b0;
        while (board.pending_moves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results for %0d requests under random gaps and stalls.",
                 board.moves_checked, board.points_noted);
        $display("Zero-radius pass-throughs: %0d, clamped axes: %0d, mismatches: %0d.",
                 board.still_points, board.clamped_axes, board.mismatches);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver stalls in bursts, with free stretches between
    initial
    begin : receiver_stalls
        int n;
        @(posedge clk);
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                moved_stall <= 1'b0;
                n = calm ? 1 : $urandom_range(1, 40);
            end
            else
            begin
                moved_stall <= 1'b1;
                n = $urandom_range(1, 15);
            end
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && moved_valid === 1'b1 && moved_stall === 1'b0)
            board.check_moved(moved_req);
    end

endmodule

>>> hashed_polar_point_scatter.f
+incdir+src
src/hpps_pkg.sv
src/hashed_polar_point_scatter.sv
src/hpps_checker.sv
tb/hashed_polar_point_scatter_tb.sv
